@@ rtl/core/pmn_pkg.sv @@
// pmn_pkg: shared types and constants of the momentum perceptron neuron.
// No dependencies; imported by perceptron_momentum_neuron.
`timescale 1ns / 1ps

package pmn_pkg;

	// Command codes of an input word
	typedef enum logic [1:0] {
		CMD_VOTE   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Result kinds of an output word
	typedef enum logic [1:0] {
		KIND_VOTE   = 2'd0,
		KIND_READ   = 2'd1,
		KIND_UPDATE = 2'd2
	} kind_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_VMUL,
		ST_VACC,
		ST_VSUM,
		ST_READ,
		ST_UDELTA,
		ST_UMOM,
		ST_UDX,
		ST_USTEP,
		ST_UWR,
		ST_UBMUL,
		ST_UBSTEP,
		ST_UBIAS
	} state_t;

	localparam int LR_W = 17;

	// 0.9 in Q0.16, held as a signed multiplier operand
	localparam logic signed [32:0] MOMENTUM_Q16 = 33'sd58982;

	localparam logic [LR_W-1:0] LEARN_RATE_RST = 17'd6554;

endpackage

@@ rtl/core/pmn_ram.sv @@
// pmn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; used for the weight and momentum stores.
`timescale 1ns / 1ps

module pmn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/perceptron_momentum_neuron.sv @@
// perceptron_momentum_neuron: top level of the single-neuron perceptron with momentum.
// Depends on pmn_pkg (types, constants) and pmn_ram (weight and momentum stores).
`timescale 1ns / 1ps

// One perceptron neuron in Q16.16 fixed point. Each input word carries one element of a
// vector. A vote word adds weight*element into a 48-bit saturating accumulator; the word
// flagged last returns the 32-bit saturated sum of accumulator and bias and clears the
// accumulator. An update word forms delta = learn_rate*error_offset and updates one weight
// and its momentum with step = delta*element + 0.9*momentum; the last update word also
// steps the bias and returns the new bias. A read word returns one weight. error_flag is
// set for a read at or past VEC_LEN and for a last word whose index is not VEC_LEN-1.
// Every product is floored after the 16-bit shift. Timing: the block takes one word at a
// time. A vote word passes the load, multiply and accumulate states (and sum when last); an
// update word load, delta, momentum, delta*element, step and write (and bias multiply,
// bias step and bias when last); a read word load and read; an unused command stays idle.
// The single shared 33x33 multiplier serves one product at a time, and the weight and
// momentum RAMs have registered read data. A word that produces a result waits in its final
// step while the previous result word is still stalled at the output. Weights and momenta
// reset to zero through per-entry valid bits; no clearing pass is needed. learn_rate may be
// rewritten at any time the block is idle; its write port is always ready.
module perceptron_momentum_neuron #(
	parameter int VEC_LEN = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pmn_pkg::LR_W-1:0]      learn_rate,
	// input words
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [7:0]                    elem_index,
	input  logic signed [31:0]            elem_value,
	input  logic signed [31:0]            error_offset,
	input  logic                          last_elem,
	// result words
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic signed [31:0]            result_value,
	output logic                          error_flag
);

	import pmn_pkg::*;

	localparam int AW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v[49:31] == {19{v[49]}}) begin
			return v[31:0];
		end
		return v[49] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v[48] == v[47]) begin
			return v[47:0];
		end
		return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
	endfunction

	// Sequencer and control state
	state_t state_q, state_d;
	logic [LR_W-1:0] lr_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] bias_q, bmom_q;
	logic [VEC_LEN-1:0] vld_q;

	// Captured word
	cmd_t cmd_q;
	logic [7:0] idx_q;
	logic signed [31:0] x_q, off_q;
	logic last_q;

	// Operands and intermediate results
	logic signed [31:0] w_q, m_q, delta_q, mterm_q, step_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;

	// Output register
	logic out_valid_q;
	kind_t result_kind_q;
	logic signed [31:0] result_value_q;
	logic error_flag_q;

	// RAM ports
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0] w_rdata, m_rdata;

	logic in_accept, in_range, bad_last, out_free, out_load;
	logic entry_ok;
	kind_t res_kind;
	logic signed [31:0] res_value;
	logic res_err;

	logic signed [49:0] prod_sh;
	logic signed [48:0] acc_sum;
	logic signed [49:0] vote_sum, step_sum, bstep_sum, w_sum, b_sum;
	logic signed [31:0] w_new, b_new;

	assign in_accept = in_valid && !in_stall;
	assign in_range  = {1'b0, idx_q} < 9'(VEC_LEN);
	assign bad_last  = idx_q != 8'(VEC_LEN - 1);
	assign out_free  = !out_valid_q || !out_stall;
	assign entry_ok  = in_range ? vld_q[idx_q[AW-1:0]] : 1'b0;

	// Shifted product: floor(prod / 2^16)
	assign prod_sh   = prod_q[65:16];
	assign acc_sum   = 49'(acc_q) + 49'(signed'(prod_sh[47:0]));
	assign vote_sum  = 50'(acc_q) + 50'(bias_q);
	assign step_sum  = prod_sh + 50'(mterm_q);
	assign bstep_sum = 50'(delta_q) + prod_sh;
	assign w_sum     = 50'(w_q) + 50'(step_q);
	assign b_sum     = 50'(bias_q) + 50'(step_q);
	assign w_new     = sat32(w_sum);
	assign b_new     = sat32(b_sum);

	assign ram_raddr = (state_q == ST_IDLE) ? elem_index[AW-1:0] : idx_q[AW-1:0];

	pmn_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_weight_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (w_new),
		.raddr (ram_raddr),
		.rdata (w_rdata)
	);

	pmn_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_momentum_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (step_q),
		.raddr (ram_raddr),
		.rdata (m_rdata)
	);

	// Next state, handshake, multiplier operand select and result assembly
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		res_kind  = KIND_VOTE;
		res_value = '0;
		res_err   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && cmd_t'(command) != CMD_NONE) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				unique case (cmd_q)
					CMD_VOTE:   state_d = ST_VMUL;
					CMD_UPDATE: state_d = ST_UDELTA;
					CMD_READ:   state_d = ST_READ;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_VMUL: begin
				mul_a   = 33'(w_q);
				mul_b   = 33'(x_q);
				state_d = ST_VACC;
			end
			ST_VACC: begin
				state_d = last_q ? ST_VSUM : ST_IDLE;
			end
			ST_VSUM: begin
				res_kind  = KIND_VOTE;
				res_value = sat32(vote_sum);
				res_err   = bad_last;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				res_kind  = KIND_READ;
				res_value = w_q;
				res_err   = !in_range;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_UDELTA: begin
				mul_a   = {16'd0, lr_q};
				mul_b   = 33'(off_q);
				state_d = ST_UMOM;
			end
			ST_UMOM: begin
				mul_a   = 33'(m_q);
				mul_b   = MOMENTUM_Q16;
				state_d = ST_UDX;
			end
			ST_UDX: begin
				mul_a   = 33'(delta_q);
				mul_b   = 33'(x_q);
				state_d = ST_USTEP;
			end
			ST_USTEP: begin
				state_d = ST_UWR;
			end
			ST_UWR: begin
				ram_we  = in_range;
				state_d = last_q ? ST_UBMUL : ST_IDLE;
			end
			ST_UBMUL: begin
				mul_a   = 33'(bmom_q);
				mul_b   = MOMENTUM_Q16;
				state_d = ST_UBSTEP;
			end
			ST_UBSTEP: begin
				state_d = ST_UBIAS;
			end
			ST_UBIAS: begin
				res_kind  = KIND_UPDATE;
				res_value = b_new;
				res_err   = bad_last;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lr_q        <= LEARN_RATE_RST;
			acc_q       <= '0;
			bias_q      <= '0;
			bmom_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				lr_q <= learn_rate;
			end
			if (state_q == ST_VACC && in_range) begin
				acc_q <= sat48(acc_sum);
			end
			if (state_q == ST_VSUM && out_load) begin
				acc_q <= '0;
			end
			if (ram_we) begin
				vld_q[idx_q[AW-1:0]] <= 1'b1;
			end
			if (state_q == ST_UBIAS && out_load) begin
				bias_q <= b_new;
				bmom_q <= step_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_accept) begin
			cmd_q  <= cmd_t'(command);
			idx_q  <= elem_index;
			x_q    <= elem_value;
			off_q  <= error_offset;
			last_q <= last_elem;
		end
		if (state_q == ST_LOAD) begin
			// never-written entries read as zero
			w_q <= entry_ok ? signed'(w_rdata) : 32'sd0;
			m_q <= entry_ok ? signed'(m_rdata) : 32'sd0;
		end
		if (state_q == ST_UMOM) begin
			delta_q <= sat32(prod_sh);
		end
		if (state_q == ST_UDX) begin
			mterm_q <= prod_sh[31:0];
		end
		if (state_q == ST_USTEP) begin
			step_q <= sat32(step_sum);
		end
		if (state_q == ST_UBSTEP) begin
			step_q <= sat32(bstep_sum);
		end
		if (out_load) begin
			result_kind_q  <= res_kind;
			result_value_q <= res_value;
			error_flag_q   <= res_err;
		end
	end

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign result_kind  = result_kind_q;
	assign result_value = result_value_q;
	assign error_flag   = error_flag_q;

	// A word that starts work blocks the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd_t'(command) != CMD_NONE) |=> in_stall)
		else $error("input taken while a word is in progress");

	// A new result never overwrites a word still stalled at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");

	// The vote sum clears the accumulator
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VSUM && out_load) |=> (acc_q == '0))
		else $error("accumulator not cleared after vote sum");

	// Store writes only at in-range indexes
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> in_range)
		else $error("store write at out-of-range index");

endmodule
